// ===== hw/rtl/dep_pkg.sv =====
package dep_pkg;

  // payload widths
  localparam int unsigned ReqW   = 2;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 7;

  // request codes
  typedef enum logic [ReqW-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REM_MIN = 2'd1,
    REQ_REM_MAX = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  // status codes
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef logic signed [ValW-1:0] value_t;

endpackage

// ===== hw/rtl/dep_if.sv =====
// request word channel
interface dep_req_if;
  logic                            valid;
  logic                            ready;
  logic [dep_pkg::ReqW-1:0]        req_type;
  logic signed [dep_pkg::ValW-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

// response word channel
interface dep_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [dep_pkg::ValW-1:0] removed_value;
  logic [dep_pkg::StatW-1:0]       status;
  logic [dep_pkg::CountW-1:0]      item_count;

  modport source (output valid, removed_value, status, item_count, input ready);
  modport sink (input valid, removed_value, status, item_count, output ready);
endinterface

// ===== hw/rtl/double_ended_priority_queue.sv =====
// Insert sifts the new value up in each heap in turn, min heap first, then max heap;
// removal: root read, partner delete in the other heap, root delete.
// One request at a time; each sift level takes a memory read and then a compare/move
// step on the shared compare logic and heap memories.
// Full, empty and unknown requests answer in the cycle after acceptance.
// Reset clears the count and control; heap memories need no clearing.
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input logic clk_i,
  input logic rst_ni,
  dep_req_if.sink   req_i,
  dep_rsp_if.source rsp_o
);
  import dep_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = IW + 2;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_SRC  = 4'd2;
  localparam logic [3:0] S_LAST = 4'd3;
  localparam logic [3:0] S_UPRD = 4'd4;
  localparam logic [3:0] S_UPEV = 4'd5;
  localparam logic [3:0] S_DNRD = 4'd6;
  localparam logic [3:0] S_DNEV = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;

  // operation phases
  localparam logic [1:0] PH_INS1 = 2'd0;
  localparam logic [1:0] PH_INS2 = 2'd1;
  localparam logic [1:0] PH_DEL1 = 2'd2;
  localparam logic [1:0] PH_DEL2 = 2'd3;

  function automatic logic before_f(logic is_max, value_t x, value_t y);
    before_f = is_max ? (x > y) : (x < y);
  endfunction

  // heap memories: index 0 min heap, 1 max heap; link of heap h points into heap !h
  value_t        key_min_mem [CAPACITY];
  value_t        key_max_mem [CAPACITY];
  logic [IW-1:0] lnk_min_mem [CAPACITY];
  logic [IW-1:0] lnk_max_mem [CAPACITY];

  logic [3:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic          h_q, h_d, src_q, src_d, moved_q, moved_d;
  logic [IW-1:0] i_q, i_d, l_q, l_d;
  value_t        k_q, k_d, rem_q, rem_d;
  logic [CW-1:0] lim_q, lim_d, cnt_q, cnt_d;

  logic                  rsp_valid_q, rsp_valid_d;
  value_t                rsp_val_q, rsp_val_d;
  logic [StatW-1:0]      rsp_st_q, rsp_st_d;
  logic [CountW-1:0]     rsp_cnt_q, rsp_cnt_d;

  logic [IW-1:0] ra_a, ra_b;
  value_t        key_a_q [2];
  value_t        key_b_q [2];
  logic [IW-1:0] lnk_a_q [2];
  logic [IW-1:0] lnk_b_q [2];

  logic          key_we [2];
  logic [IW-1:0] key_wa [2];
  value_t        key_wd [2];
  logic          lnk_we [2];
  logic [IW-1:0] lnk_wa [2];
  logic [IW-1:0] lnk_wd [2];

  logic          in_acc;
  logic          wr_en;
  logic [IW-1:0] wr_slot, wr_lnk;
  value_t        wr_key;
  logic          fin;
  value_t        fin_val;
  logic [StatW-1:0] fin_st;
  logic [CW-1:0] last;
  logic [IW-1:0] par;
  logic [XW-1:0] lft, rgt;
  logic          use_r;
  value_t        ck;
  logic [IW-1:0] cl, ci;

  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign last        = cnt_q - CW'(1);
  assign par         = (i_q - IW'(1)) >> 1;
  assign lft         = (XW'(i_q) << 1) + XW'(1);
  assign rgt         = lft + XW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    h_d     = h_q;
    src_d   = src_q;
    moved_d = moved_q;
    i_d     = i_q;
    l_d     = l_q;
    k_d     = k_q;
    rem_d   = rem_q;
    lim_d   = lim_q;
    cnt_d   = cnt_q;
    ra_a    = '0;
    ra_b    = '0;
    wr_en   = 1'b0;
    wr_slot = i_q;
    wr_key  = k_q;
    wr_lnk  = l_q;
    fin     = 1'b0;
    fin_val = '0;
    fin_st  = ST_OK;
    use_r   = 1'b0;
    ck      = key_a_q[h_q];
    cl      = lnk_a_q[h_q];
    ci      = lft[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_i.req_type == REQ_INSERT) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              fin    = 1'b1;
              fin_st = ST_FULL;
            end else begin
              h_d     = 1'b0;
              i_d     = cnt_q[IW-1:0];
              l_d     = cnt_q[IW-1:0];
              k_d     = req_i.value;
              moved_d = 1'b0;
              phase_d = PH_INS1;
              state_d = S_UPRD;
            end
          end else if (req_i.req_type == REQ_REM_MIN || req_i.req_type == REQ_REM_MAX) begin
            if (cnt_q == '0) begin
              fin    = 1'b1;
              fin_st = ST_EMPTY;
            end else begin
              src_d   = (req_i.req_type == REQ_REM_MAX);
              state_d = S_ROOT;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_ROOT: begin
        rem_d = key_a_q[src_q];
        if (CW'(lnk_a_q[src_q]) != last) begin
          h_d     = !src_q;
          i_d     = lnk_a_q[src_q];
          ra_a    = last[IW-1:0];
          phase_d = PH_DEL1;
          state_d = S_LAST;
        end else begin
          state_d = S_SRC;
        end
      end
      S_SRC: begin
        if (cnt_q == CW'(1)) begin
          cnt_d   = last;
          fin     = 1'b1;
          fin_val = rem_q;
          state_d = S_IDLE;
        end else begin
          h_d     = src_q;
          i_d     = '0;
          ra_a    = last[IW-1:0];
          phase_d = PH_DEL2;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        k_d     = key_a_q[h_q];
        l_d     = lnk_a_q[h_q];
        moved_d = 1'b0;
        lim_d   = last;
        state_d = S_UPRD;
      end
      S_UPRD: begin
        ra_a = par;
        if (i_q == '0) begin
          state_d = (moved_q || phase_q == PH_INS1 || phase_q == PH_INS2) ? S_WR : S_DNRD;
        end else begin
          state_d = S_UPEV;
        end
      end
      S_UPEV: begin
        if (before_f(h_q, k_q, key_a_q[h_q])) begin
          wr_en   = 1'b1;
          wr_key  = key_a_q[h_q];
          wr_lnk  = lnk_a_q[h_q];
          i_d     = par;
          moved_d = 1'b1;
          state_d = S_UPRD;
        end else begin
          state_d = (moved_q || phase_q == PH_INS1 || phase_q == PH_INS2) ? S_WR : S_DNRD;
        end
      end
      S_DNRD: begin
        if (lft < XW'(lim_q)) begin
          ra_a    = lft[IW-1:0];
          ra_b    = (rgt < XW'(lim_q)) ? rgt[IW-1:0] : lft[IW-1:0];
          state_d = S_DNEV;
        end else begin
          state_d = S_WR;
        end
      end
      S_DNEV: begin
        use_r = (rgt < XW'(lim_q)) && before_f(h_q, key_b_q[h_q], key_a_q[h_q]);
        if (use_r) begin
          ck = key_b_q[h_q];
          cl = lnk_b_q[h_q];
          ci = rgt[IW-1:0];
        end
        if (before_f(h_q, ck, k_q)) begin
          wr_en   = 1'b1;
          wr_key  = ck;
          wr_lnk  = cl;
          i_d     = ci;
          state_d = S_DNRD;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        wr_en = 1'b1;
        unique case (phase_q)
          PH_INS1: begin
            h_d     = 1'b1;
            i_d     = cnt_q[IW-1:0];
            l_d     = i_q;
            moved_d = 1'b0;
            phase_d = PH_INS2;
            state_d = S_UPRD;
          end
          PH_INS2: begin
            cnt_d   = cnt_q + CW'(1);
            fin     = 1'b1;
            state_d = S_IDLE;
          end
          PH_DEL1: begin
            state_d = S_SRC;
          end
          default: begin
            cnt_d   = last;
            fin     = 1'b1;
            fin_val = rem_q;
            state_d = S_IDLE;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory write controls: own slot in heap h, back link in the other heap
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      key_we[j] = 1'b0;
      key_wa[j] = wr_slot;
      key_wd[j] = wr_key;
      lnk_we[j] = 1'b0;
      lnk_wa[j] = wr_slot;
      lnk_wd[j] = wr_lnk;
    end
    if (wr_en) begin
      key_we[h_q]  = 1'b1;
      lnk_we[h_q]  = 1'b1;
      lnk_we[!h_q] = 1'b1;
      lnk_wa[!h_q] = wr_lnk;
      lnk_wd[!h_q] = wr_slot;
    end
  end

  // response register
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_val_d   = rsp_val_q;
    rsp_st_d    = rsp_st_q;
    rsp_cnt_d   = rsp_cnt_q;
    if (fin) begin
      rsp_valid_d = 1'b1;
      rsp_val_d   = fin_val;
      rsp_st_d    = fin_st;
      rsp_cnt_d   = CountW'(cnt_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INS1;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    src_q     <= src_d;
    moved_q   <= moved_d;
    i_q       <= i_d;
    l_q       <= l_d;
    k_q       <= k_d;
    rem_q     <= rem_d;
    lim_q     <= lim_d;
    rsp_val_q <= rsp_val_d;
    rsp_st_q  <= rsp_st_d;
    rsp_cnt_q <= rsp_cnt_d;
  end

  // heap memories, registered reads
  always_ff @(posedge clk_i) begin
    if (key_we[0]) key_min_mem[key_wa[0]] <= key_wd[0];
    if (key_we[1]) key_max_mem[key_wa[1]] <= key_wd[1];
    if (lnk_we[0]) lnk_min_mem[lnk_wa[0]] <= lnk_wd[0];
    if (lnk_we[1]) lnk_max_mem[lnk_wa[1]] <= lnk_wd[1];
    key_a_q[0] <= key_min_mem[ra_a];
    key_a_q[1] <= key_max_mem[ra_a];
    key_b_q[0] <= key_min_mem[ra_b];
    key_b_q[1] <= key_max_mem[ra_b];
    lnk_a_q[0] <= lnk_min_mem[ra_a];
    lnk_a_q[1] <= lnk_max_mem[ra_a];
    lnk_b_q[0] <= lnk_min_mem[ra_b];
    lnk_b_q[1] <= lnk_max_mem[ra_b];
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rsp_val_q;
  assign rsp_o.status        = rsp_st_q;
  assign rsp_o.item_count    = rsp_cnt_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("count beyond capacity");
  a_busy_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !rsp_valid_q) else $error("response pending while busy");
  a_acc_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE) || rsp_valid_q) else $error("request lost");
  a_wr_ends_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && phase_q == PH_INS2) |=> rsp_valid_q && cnt_q == $past(cnt_q) + CW'(1))
    else $error("insert count slip");
endmodule
